/* sv/fpfl_pkg.sv */
// Package for the fixed pool free list allocator.
// Holds field widths, status, opcode and register codes, and the control state type.
// No dependencies; every module of the block imports it.
package fpfl_pkg;

    // Field widths of the stream words.
    localparam int HANDLE_W  = 10;
    localparam int CNT_W     = 11;
    localparam int TOT_W     = 32;
    localparam int STAT_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 11;
    localparam int IN_DATA_W = 16;
    localparam int OUT_DATA_W = 112;

    // Width of the raw block product, block_count times block size (11 x 11 bits).
    localparam int RAW_W = 22;

    // Largest live count before it saturates.
    localparam logic [CNT_W-1:0] LIVE_MAX = '1;

    // Opcodes.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_OOM     = 3'd1;
    localparam logic [STAT_W-1:0] ST_ILLEGAL = 3'd2;
    localparam logic [STAT_W-1:0] ST_DOUBLE  = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ELEMENTS_PER_BLOCK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LIMIT        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_DOUBLE_FREE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_RANGE        = 2'd3;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] EPB_RESET   = 11'd64;
    localparam logic [CFG_W-1:0] LIMIT_RESET = 11'd16;

    // Control states.
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

endpackage

/* sv/fixed_pool_free_list_allocator.sv */
// A request word accepted in S_IDLE moves to S_EXEC, which loads its result word into
// the output register once that register is free; an allocation that must grow the pool
// before bumping grows it in S_EXEC first. A new request is taken only in S_IDLE, after
// the synchronous read of the free stack and freed mark memories and the read-modify-write
// update of the previous one. Reset: all counters clear at once; a clearing pass walks the
// freed mark memory's min(POOL_DEPTH, 1024) entries, one a cycle, with s_axis_tready low.
//
// Top level of the fixed pool free list allocator.
// Depends on fpfl_pkg; holds the free stack and freed mark memories.
module fixed_pool_free_list_allocator #(
    parameter int POOL_DEPTH = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Request stream.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [9:0] handle_in, [15:10] zero
    input  logic [fpfl_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [0] opcode
    input  logic [0:0]                       s_axis_tuser,
    // Result stream.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [9:0] handle_out, [12:10] status, [23:13] in_use_count, [34:24] free_count,
    // [45:35] blocks_grown, [77:46] total_allocs, [109:78] total_frees, [111:110] zero
    output logic [fpfl_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // Configuration write channel.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fpfl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fpfl_pkg::CFG_W-1:0]       cfg_data
);

    import fpfl_pkg::*;

    localparam int CW         = $clog2(POOL_DEPTH + 1);
    localparam int SW         = $clog2(POOL_DEPTH);
    localparam int MARK_DEPTH = (POOL_DEPTH < 1024) ? POOL_DEPTH : 1024;
    localparam int MW         = $clog2(MARK_DEPTH);
    localparam int CMP_W      = (CW > HANDLE_W) ? CW : HANDLE_W;

    // Configuration registers.
    logic [CFG_W-1:0]    epb_reg;
    logic [CFG_W-1:0]    limit_reg;
    logic                cdf_reg;
    logic                crng_reg;

    // Control and allocator state.
    state_t              state_reg, state_next;
    logic [MW-1:0]       clr_cnt_reg;
    logic                op_reg;
    logic [HANDLE_W-1:0] hin_reg;
    logic [RAW_W-1:0]    raw_reg, raw_next;
    logic                grow_done_reg, grow_done_next;
    logic [CW-1:0]       free_top_reg, free_top_next;
    logic [CW-1:0]       bump_reg, bump_next;
    logic [CNT_W-1:0]    bc_reg, bc_next;
    logic [CNT_W-1:0]    live_reg, live_next;
    logic [TOT_W-1:0]    atot_reg, atot_next;
    logic [TOT_W-1:0]    ftot_reg, ftot_next;

    // Output register.
    logic                    out_valid_reg;
    logic [OUT_DATA_W-1:0]   out_data_reg;
    logic                    out_load;
    logic [HANDLE_W-1:0]     res_handle;
    logic [STAT_W-1:0]       res_status;

    // Memories and their ports.
    logic [HANDLE_W-1:0]     stack_mem [POOL_DEPTH];
    logic                    mark_mem [MARK_DEPTH];
    logic [HANDLE_W-1:0]     stack_rd_reg;
    logic                    mark_rd_reg;
    logic                    stack_we;
    logic                    mark_we;
    logic [MW-1:0]           mark_wa;
    logic                    mark_wd;

    // Decode helpers.
    logic                    in_accept;
    logic                    out_free;
    logic [CFG_W-1:0]        per_eff;
    logic [CW-1:0]           cap;
    logic                    can_grow;
    logic                    grow_first;
    logic [CW-1:0]           bump_inc;
    logic                    range_bad;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // Capacity and growth conditions from the registered block product.
    assign per_eff   = (epb_reg == '0) ? CFG_W'(1) : epb_reg;
    assign cap       = (raw_reg >= RAW_W'(POOL_DEPTH)) ? CW'(POOL_DEPTH) : CW'(raw_reg);
    assign can_grow  = (bc_reg < limit_reg) && (cap < CW'(POOL_DEPTH));
    assign bump_inc  = bump_reg + 1'b1;
    assign range_bad = (CMP_W'(hin_reg) >= CMP_W'(POOL_DEPTH))
                    || (crng_reg && (CMP_W'(hin_reg) >= CMP_W'(cap)));

    // An allocation with an empty stack and a full pool grows the pool first, if it can grow.
    assign grow_first = (op_reg == OP_ALLOC) && (free_top_reg == '0) && (bump_reg >= cap)
                     && !grow_done_reg && can_grow;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epb_reg   <= EPB_RESET;
            limit_reg <= LIMIT_RESET;
            cdf_reg   <= 1'b0;
            crng_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ELEMENTS_PER_BLOCK: epb_reg   <= cfg_data;
                REG_BLOCK_LIMIT:        limit_reg <= cfg_data;
                REG_CHECK_DOUBLE_FREE:  cdf_reg   <= cfg_data[0];
                REG_CHECK_RANGE:        crng_reg  <= cfg_data[0];
                default:                ;
            endcase
        end
    end

    // State register and allocator counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            grow_done_reg <= 1'b0;
            free_top_reg  <= '0;
            bump_reg      <= '0;
            bc_reg        <= '0;
            live_reg      <= '0;
            atot_reg      <= '0;
            ftot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            grow_done_reg <= grow_done_next;
            free_top_reg  <= free_top_next;
            bump_reg      <= bump_next;
            bc_reg        <= bc_next;
            live_reg      <= live_next;
            atot_reg      <= atot_next;
            ftot_reg      <= ftot_next;
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request and product registers, and the result word.
    always_ff @(posedge clk)
    begin
        raw_reg <= raw_next;
        if (in_accept)
        begin
            op_reg  <= s_axis_tuser[0];
            hin_reg <= s_axis_tdata[HANDLE_W-1:0];
        end
        if (out_load)
        begin
            out_data_reg <= {2'b00, ftot_next, atot_next, bc_next, CNT_W'(free_top_next),
                             live_next, res_status, res_handle};
        end
    end

    // Free stack memory: read the top entry on accept, push on an accepted free.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            stack_rd_reg <= stack_mem[SW'(free_top_reg - 1'b1)];
        end
        if (stack_we)
        begin
            stack_mem[free_top_reg[SW-1:0]] <= hin_reg;
        end
    end

    // Freed mark memory: read the mark of the handle on accept, clear or set on update.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mark_rd_reg <= mark_mem[s_axis_tdata[MW-1:0]];
        end
        if (mark_we)
        begin
            mark_mem[mark_wa] <= mark_wd;
        end
    end

    // Next state, update of the counters and memory writes.
    always_comb
    begin
        state_next     = state_reg;
        raw_next       = raw_reg;
        grow_done_next = grow_done_reg;
        free_top_next  = free_top_reg;
        bump_next      = bump_reg;
        bc_next        = bc_reg;
        live_next      = live_reg;
        atot_next      = atot_reg;
        ftot_next      = ftot_reg;
        out_load       = 1'b0;
        res_handle     = '0;
        res_status     = ST_OK;
        stack_we       = 1'b0;
        mark_we        = 1'b0;
        mark_wa        = clr_cnt_reg;
        mark_wd        = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                mark_we = 1'b1;
                if (clr_cnt_reg == MW'(MARK_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_accept)
                begin
                    raw_next       = RAW_W'(bc_reg) * RAW_W'(per_eff);
                    grow_done_next = 1'b0;
                    state_next     = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (op_reg == OP_ALLOC)
                begin
                    if (free_top_reg != '0)
                    begin
                        // Pop the free stack.
                        res_handle = stack_rd_reg;
                        if (out_free)
                        begin
                            free_top_next = free_top_reg - 1'b1;
                            mark_wa       = stack_rd_reg[MW-1:0];
                            mark_we       = cdf_reg
                                && ({1'b0, stack_rd_reg} < (HANDLE_W + 1)'(MARK_DEPTH));
                        end
                    end
                    else if (bump_reg >= cap && !grow_done_reg && can_grow)
                    begin
                        // Grow before bumping, then look again.
                        bc_next        = bc_reg + 1'b1;
                        raw_next       = raw_reg + RAW_W'(per_eff);
                        grow_done_next = 1'b1;
                    end
                    else if (bump_reg >= cap)
                    begin
                        res_status = ST_OOM;
                    end
                    else
                    begin
                        // Bump allocation, with eager growth when the block fills.
                        res_handle = HANDLE_W'(bump_reg);
                        if (out_free)
                        begin
                            bump_next = bump_inc;
                            mark_wa   = bump_reg[MW-1:0];
                            mark_we   = cdf_reg && (bump_reg < CW'(MARK_DEPTH));
                            if (bump_inc >= cap && can_grow)
                            begin
                                bc_next  = bc_reg + 1'b1;
                                raw_next = raw_reg + RAW_W'(per_eff);
                            end
                        end
                    end

                    if (res_status == ST_OK && out_free && !grow_first)
                    begin
                        live_next = (live_reg == LIVE_MAX) ? live_reg : live_reg + 1'b1;
                        atot_next = atot_reg + 1'b1;
                    end
                end
                else
                begin
                    // Free checks in order: range, double free, full stack.
                    if (range_bad)
                    begin
                        res_status = ST_ILLEGAL;
                    end
                    else if (cdf_reg && mark_rd_reg)
                    begin
                        res_status = ST_DOUBLE;
                    end
                    else if (free_top_reg == CW'(POOL_DEPTH))
                    begin
                        res_status = ST_FULL;
                    end
                    else if (out_free)
                    begin
                        stack_we      = 1'b1;
                        mark_we       = cdf_reg;
                        mark_wa       = hin_reg[MW-1:0];
                        mark_wd       = 1'b1;
                        free_top_next = free_top_reg + 1'b1;
                        ftot_next     = ftot_reg + 1'b1;
                        live_next     = (live_reg == '0) ? live_reg : live_reg - 1'b1;
                    end
                end

                // The result leaves once the output register can take it.
                if (!grow_first && out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    // No request is taken while the mark memory is being cleared.
    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !s_axis_tready)
        else $error("request accepted during mark clearing pass");

    // The stack pointer never passes the stack depth.
    a_free_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_top_reg <= CW'(POOL_DEPTH))
        else $error("free stack pointer beyond pool depth");

    // An accepted free pushes exactly one entry.
    a_free_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && op_reg == OP_FREE && res_status == ST_OK)
        |=> (free_top_reg == CW'($past(free_top_reg) + 1'b1)))
        else $error("accepted free did not push the stack");

    // A successful allocation counts exactly once.
    a_alloc_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && op_reg == OP_ALLOC && res_status == ST_OK)
        |=> (atot_reg == $past(atot_reg) + 1'b1))
        else $error("allocation total not advanced");
`endif

endmodule
